[hdl/spu_pkg.sv]
// Shared types, constants and coefficient table for the state-space PID update block.
package spu_pkg;

  localparam int unsigned STATE_SIZE = 6;
  localparam int unsigned IDX_W      = 3;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_SIZE - 1);

  localparam int unsigned SMP_W  = 16;   // Q4.12 samples and gains
  localparam int unsigned DATA_W = 32;   // Q8.24 state, integrator, drive
  localparam int unsigned A_W    = 16;   // multiplier operand A
  localparam int unsigned B_W    = 40;   // multiplier operand B (error, derivative)
  localparam int unsigned P_W    = A_W + B_W;
  localparam int unsigned ACC_W  = 58;

  localparam int unsigned SHIFT_STATE = 14;
  localparam int unsigned SHIFT_OUT   = 12;
  localparam logic signed [ACC_W-1:0] BIAS_STATE = ACC_W'(1) << (SHIFT_STATE - 1);
  localparam logic signed [ACC_W-1:0] BIAS_OUT   = ACC_W'(1) << (SHIFT_OUT - 1);

  localparam int unsigned UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;
  typedef logic [IDX_W-1:0] idx_t;

  // Program labels
  localparam upc_t UPC_IDLE       = 4'd0;
  localparam upc_t UPC_ROW_FIRST  = 4'd1;
  localparam upc_t UPC_ROW_LOOP   = 4'd2;
  localparam upc_t UPC_ROW_TAIL   = 4'd3;
  localparam upc_t UPC_ROW_WR     = 4'd4;
  localparam upc_t UPC_MEAS_FIRST = 4'd5;
  localparam upc_t UPC_MEAS_LOOP  = 4'd6;
  localparam upc_t UPC_MEAS_TAIL  = 4'd7;
  localparam upc_t UPC_ERR        = 4'd8;
  localparam upc_t UPC_DERIV      = 4'd9;
  localparam upc_t UPC_RATE_ADD   = 4'd10;
  localparam upc_t UPC_INTEG      = 4'd11;
  localparam upc_t UPC_DRV_I      = 4'd12;
  localparam upc_t UPC_DRV_D      = 4'd13;
  localparam upc_t UPC_DRV_ADD    = 4'd14;
  localparam upc_t UPC_DRIVE      = 4'd15;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_COEF_STATE,
    MUL_GAIN_SMP,
    MUL_STATE_SMP,
    MUL_RATE_ERR,
    MUL_PGAIN_ERR,
    MUL_IGAIN_INTEG,
    MUL_DGAIN_DERIV
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_BIAS_STATE,
    ACC_BIAS_OUT,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_LOAD,
    WR_NXT,
    WR_ERR,
    WR_DERIV,
    WR_INTEG,
    WR_DRIVE
  } wr_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC
  } cnt_op_e;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_J_LOOP,
    JMP_I_LOOP,
    JMP_WAIT_IN,
    JMP_WAIT_OUT
  } jmp_e;

  typedef enum logic [2:0] {
    CFG_SETPOINT,
    CFG_PROP_GAIN,
    CFG_INTEG_GAIN,
    CFG_DERIV_GAIN,
    CFG_INTEG_RATE,
    CFG_INPUT_GAIN
  } cfg_idx_e;

  typedef struct packed {
    mul_sel_e mul;
    acc_op_e  acc;
    wr_e      wr;
    cnt_op_e  i_op;
    cnt_op_e  j_op;
    jmp_e     jmp;
    upc_t     target;
  } ucode_t;

  // Control handed from the sequencer to the datapath each cycle
  typedef struct packed {
    mul_sel_e mul;
    acc_op_e  acc;
    wr_e      wr;
    idx_t     i;
    idx_t     j;
  } ctrl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] setpoint;
    logic signed [SMP_W-1:0]  prop_gain;
    logic signed [SMP_W-1:0]  integ_gain;
    logic signed [SMP_W-1:0]  deriv_gain;
    logic signed [SMP_W-1:0]  integ_rate;
    logic signed [SMP_W-1:0]  input_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     clip;
  } sat_t;

  localparam logic signed [DATA_W-1:0] RST_SETPOINT   = 32'sd8388608;
  localparam logic signed [SMP_W-1:0]  RST_PROP_GAIN  = 16'sd8192;
  localparam logic signed [SMP_W-1:0]  RST_INTEG_GAIN = 16'sd410;
  localparam logic signed [SMP_W-1:0]  RST_DERIV_GAIN = 16'sd205;
  localparam logic signed [SMP_W-1:0]  RST_INTEG_RATE = 16'sd41;
  localparam logic signed [SMP_W-1:0]  RST_INPUT_GAIN = 16'sd82;

  // Transition matrix, Q2.14
  localparam logic signed [A_W-1:0] COEF [STATE_SIZE][STATE_SIZE] = '{
    '{16'sd16056, 16'sd164,   16'sd0,     16'sd328,   16'sd0,     16'sd164},
    '{16'sd0,     16'sd15892, 16'sd492,   16'sd0,     16'sd164,   16'sd0},
    '{16'sd164,   16'sd0,     16'sd15729, 16'sd328,   16'sd0,     16'sd328},
    '{16'sd0,     16'sd328,   16'sd0,     16'sd15565, 16'sd492,   16'sd0},
    '{16'sd328,   16'sd0,     16'sd164,   16'sd0,     16'sd15892, 16'sd164},
    '{16'sd0,     16'sd164,   16'sd0,     16'sd492,   16'sd0,     16'sd15729}
  };

endpackage

[hdl/spu_seq.sv]
// Microcode sequencer: program ROM, program counter and row/column counters.
module spu_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_busy_i,
  output logic           idle_o,
  output spu_pkg::ctrl_t ctrl_o
);
  import spu_pkg::*;

  upc_t   upc_q, upc_d;
  idx_t   i_q, i_d;
  idx_t   j_q, j_d;
  ucode_t word;
  logic   wait_hit;

  function automatic ucode_t rom(input upc_t pc);
    ucode_t w;
    w = '{mul: MUL_NONE, acc: ACC_HOLD, wr: WR_NONE, i_op: CNT_HOLD, j_op: CNT_HOLD,
          jmp: JMP_NEXT, target: UPC_IDLE};
    unique case (pc)
      UPC_IDLE: begin
        w.wr = WR_LOAD; w.i_op = CNT_CLEAR; w.j_op = CNT_CLEAR;
        w.jmp = JMP_WAIT_IN; w.target = UPC_ROW_FIRST;
      end
      UPC_ROW_FIRST: begin
        w.mul = MUL_COEF_STATE; w.acc = ACC_BIAS_STATE; w.j_op = CNT_INC;
      end
      UPC_ROW_LOOP: begin
        w.mul = MUL_COEF_STATE; w.acc = ACC_ADD; w.j_op = CNT_INC;
        w.jmp = JMP_J_LOOP; w.target = UPC_ROW_LOOP;
      end
      UPC_ROW_TAIL: begin
        w.mul = MUL_GAIN_SMP; w.acc = ACC_ADD; w.j_op = CNT_CLEAR;
      end
      UPC_ROW_WR: begin
        w.wr = WR_NXT; w.i_op = CNT_INC; w.jmp = JMP_I_LOOP; w.target = UPC_ROW_FIRST;
      end
      UPC_MEAS_FIRST: begin
        w.mul = MUL_STATE_SMP; w.acc = ACC_BIAS_OUT; w.j_op = CNT_INC;
      end
      UPC_MEAS_LOOP: begin
        w.mul = MUL_STATE_SMP; w.acc = ACC_ADD; w.j_op = CNT_INC;
        w.jmp = JMP_J_LOOP; w.target = UPC_MEAS_LOOP;
      end
      UPC_MEAS_TAIL: begin
        w.acc = ACC_ADD; w.j_op = CNT_CLEAR;
      end
      UPC_ERR: begin
        w.wr = WR_ERR;
      end
      UPC_DERIV: begin
        w.mul = MUL_RATE_ERR; w.acc = ACC_BIAS_OUT; w.wr = WR_DERIV;
      end
      UPC_RATE_ADD: begin
        w.acc = ACC_ADD;
      end
      UPC_INTEG: begin
        w.mul = MUL_PGAIN_ERR; w.acc = ACC_BIAS_OUT; w.wr = WR_INTEG;
      end
      UPC_DRV_I: begin
        w.mul = MUL_IGAIN_INTEG; w.acc = ACC_ADD;
      end
      UPC_DRV_D: begin
        w.mul = MUL_DGAIN_DERIV; w.acc = ACC_ADD;
      end
      UPC_DRV_ADD: begin
        w.acc = ACC_ADD;
      end
      UPC_DRIVE: begin
        w.wr = WR_DRIVE; w.jmp = JMP_WAIT_OUT; w.target = UPC_IDLE;
      end
      default: ;
    endcase
    return w;
  endfunction

  assign word     = rom(upc_q);
  assign wait_hit = ((word.jmp == JMP_WAIT_IN) && !in_valid_i) ||
                    ((word.jmp == JMP_WAIT_OUT) && out_busy_i);
  assign idle_o   = (upc_q == UPC_IDLE);

  always_comb begin
    upc_d = upc_q;
    i_d   = i_q;
    j_d   = j_q;
    ctrl_o = '{mul: MUL_NONE, acc: ACC_HOLD, wr: WR_NONE, i: i_q, j: j_q};
    if (!wait_hit) begin
      ctrl_o.mul = word.mul;
      ctrl_o.acc = word.acc;
      ctrl_o.wr  = word.wr;
      unique case (word.jmp)
        JMP_J_LOOP:   upc_d = (j_q != LAST_IDX) ? word.target : upc_q + 1'b1;
        JMP_I_LOOP:   upc_d = (i_q != LAST_IDX) ? word.target : upc_q + 1'b1;
        JMP_WAIT_IN,
        JMP_WAIT_OUT: upc_d = word.target;
        default:      upc_d = upc_q + 1'b1;
      endcase
      unique case (word.i_op)
        CNT_CLEAR: i_d = '0;
        CNT_INC:   i_d = i_q + 1'b1;
        default:   i_d = i_q;
      endcase
      unique case (word.j_op)
        CNT_CLEAR: j_d = '0;
        CNT_INC:   j_d = j_q + 1'b1;
        default:   j_d = j_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_IDLE;
      i_q   <= '0;
      j_q   <= '0;
    end else begin
      upc_q <= upc_d;
      i_q   <= i_d;
      j_q   <= j_d;
    end
  end

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == UPC_IDLE && !in_valid_i) |=> (upc_q == UPC_IDLE))
    else $error("sequencer left idle without an input");

  a_row_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == UPC_ROW_WR) |-> (i_q <= LAST_IDX))
    else $error("row index out of range at state write");

  a_col_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == UPC_ROW_LOOP || upc_q == UPC_MEAS_LOOP) |-> (j_q != '0 && j_q <= LAST_IDX))
    else $error("column index out of range in inner loop");

  a_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == UPC_ROW_FIRST || upc_q == UPC_MEAS_FIRST) |-> (j_q == '0))
    else $error("column index not cleared at loop start");

endmodule

[hdl/spu_dp.sv]
// Datapath: shared multiply-accumulate unit, state, integrator and result register.
module spu_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  spu_pkg::ctrl_t                         ctrl_i,
  input  spu_pkg::cfg_t                          cfg_i,
  input  logic signed [spu_pkg::SMP_W-1:0]       sample_i [spu_pkg::STATE_SIZE],
  input  logic                                   out_stall_i,
  output logic                                   out_valid_o,
  output logic signed [spu_pkg::DATA_W-1:0]      drive_o,
  output logic                                   clipped_o
);
  import spu_pkg::*;

  logic signed [SMP_W-1:0]  smp_q   [STATE_SIZE];
  logic signed [DATA_W-1:0] state_q [STATE_SIZE];
  logic signed [DATA_W-1:0] nxt_q   [STATE_SIZE];
  logic signed [DATA_W-1:0] integ_q;
  logic signed [B_W-1:0]    err_q, deriv_q;
  logic signed [P_W-1:0]    p_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     clip_q;
  logic signed [DATA_W-1:0] drive_q;
  logic                     clipped_q;
  logic                     out_valid_q;

  logic signed [A_W-1:0]    opa;
  logic signed [B_W-1:0]    opb;
  logic signed [P_W-1:0]    prod;
  logic signed [ACC_W-1:0]  err_full;
  sat_t                     nxt_sat, integ_sat, drive_sat;

  function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
    sat_t r;
    r.clip = (v[ACC_W-1:DATA_W-1] != {(ACC_W-DATA_W+1){v[ACC_W-1]}});
    if (r.clip) begin
      r.val = v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (ctrl_i.mul)
      MUL_COEF_STATE: begin
        opa = COEF[ctrl_i.i][ctrl_i.j];
        opb = B_W'(state_q[ctrl_i.j]);
      end
      MUL_GAIN_SMP: begin
        opa = cfg_i.input_gain;
        opb = B_W'(smp_q[ctrl_i.i]);
      end
      MUL_STATE_SMP: begin
        opa = smp_q[ctrl_i.j];
        opb = B_W'(nxt_q[ctrl_i.j]);
      end
      MUL_RATE_ERR: begin
        opa = cfg_i.integ_rate;
        opb = err_q;
      end
      MUL_PGAIN_ERR: begin
        opa = cfg_i.prop_gain;
        opb = err_q;
      end
      MUL_IGAIN_INTEG: begin
        opa = cfg_i.integ_gain;
        opb = B_W'(integ_q);
      end
      MUL_DGAIN_DERIV: begin
        opa = cfg_i.deriv_gain;
        opb = deriv_q;
      end
      default: ;
    endcase
  end

  assign prod = opa * opb;

  always_comb begin
    unique case (ctrl_i.acc)
      ACC_BIAS_STATE: acc_d = BIAS_STATE;
      ACC_BIAS_OUT:   acc_d = BIAS_OUT;
      ACC_ADD:        acc_d = acc_q + ACC_W'(p_q);
      default:        acc_d = acc_q;
    endcase
  end

  // Bias was preloaded, so the arithmetic shift rounds half up
  assign nxt_sat   = sat32((acc_q >>> SHIFT_STATE) + ACC_W'(p_q));
  assign integ_sat = sat32(ACC_W'(integ_q) + (acc_q >>> SHIFT_OUT));
  assign drive_sat = sat32(acc_q >>> SHIFT_OUT);
  assign err_full  = ACC_W'(cfg_i.setpoint) - (acc_q >>> SHIFT_OUT);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul != MUL_NONE) begin
      p_q <= prod;
    end
    acc_q <= acc_d;
    unique case (ctrl_i.wr)
      WR_LOAD: begin
        smp_q  <= sample_i;
        clip_q <= 1'b0;
      end
      WR_NXT: begin
        nxt_q[ctrl_i.i] <= nxt_sat.val;
        clip_q          <= clip_q | nxt_sat.clip;
      end
      WR_ERR: begin
        err_q <= err_full[B_W-1:0];
      end
      WR_DERIV: begin
        deriv_q <= err_q - B_W'(nxt_q[0]);
      end
      WR_INTEG: begin
        clip_q <= clip_q | integ_sat.clip;
      end
      WR_DRIVE: begin
        drive_q   <= drive_sat.val;
        clipped_q <= clip_q | drive_sat.clip;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STATE_SIZE; k++) begin
        state_q[k] <= '0;
      end
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.wr == WR_DERIV) begin
        state_q <= nxt_q;
      end
      if (ctrl_i.wr == WR_INTEG) begin
        integ_q <= integ_sat.val;
      end
      out_valid_q <= (out_valid_q && out_stall_i) || (ctrl_i.wr == WR_DRIVE);
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign clipped_o   = clipped_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.wr == WR_DRIVE) |-> !(out_valid_q && out_stall_i))
    else $error("result written while previous transaction still pending");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.wr == WR_LOAD) |-> (ctrl_i.mul == MUL_NONE && ctrl_i.acc == ACC_HOLD))
    else $error("sample load overlaps arithmetic");

endmodule

[hdl/state_space_pid_update_top.sv]
// One item in flight: the input is stalled until the sequencer is back in idle.
// Each item is worked through by the single shared 16x40 multiplier, stepping through
// 6x6 matrix terms, 6 injections, 6 measurement terms and 4 gains. A pending result is
// held in the output register; a new one waits only if unread.
// Reset clears the model state, integrator and result valid, and loads the default
// configuration; no clearing pass.
module state_space_pid_update_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [spu_pkg::SMP_W-1:0]    sample_0_i,
  input  logic signed [spu_pkg::SMP_W-1:0]    sample_1_i,
  input  logic signed [spu_pkg::SMP_W-1:0]    sample_2_i,
  input  logic signed [spu_pkg::SMP_W-1:0]    sample_3_i,
  input  logic signed [spu_pkg::SMP_W-1:0]    sample_4_i,
  input  logic signed [spu_pkg::SMP_W-1:0]    sample_5_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [spu_pkg::DATA_W-1:0]   drive_o,
  output logic                                clipped_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [2:0]                          cfg_index_i,
  input  logic [spu_pkg::DATA_W-1:0]          cfg_data_i
);
  import spu_pkg::*;

  cfg_t                    cfg_q;
  ctrl_t                   ctrl;
  logic                    idle;
  logic signed [SMP_W-1:0] samples [STATE_SIZE];

  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;
  assign samples[4] = sample_4_i;
  assign samples[5] = sample_5_i;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !idle;

  // Unknown register indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint   <= RST_SETPOINT;
      cfg_q.prop_gain  <= RST_PROP_GAIN;
      cfg_q.integ_gain <= RST_INTEG_GAIN;
      cfg_q.deriv_gain <= RST_DERIV_GAIN;
      cfg_q.integ_rate <= RST_INTEG_RATE;
      cfg_q.input_gain <= RST_INPUT_GAIN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SETPOINT:   cfg_q.setpoint   <= cfg_data_i;
        CFG_PROP_GAIN:  cfg_q.prop_gain  <= cfg_data_i[SMP_W-1:0];
        CFG_INTEG_GAIN: cfg_q.integ_gain <= cfg_data_i[SMP_W-1:0];
        CFG_DERIV_GAIN: cfg_q.deriv_gain <= cfg_data_i[SMP_W-1:0];
        CFG_INTEG_RATE: cfg_q.integ_rate <= cfg_data_i[SMP_W-1:0];
        CFG_INPUT_GAIN: cfg_q.input_gain <= cfg_data_i[SMP_W-1:0];
        default: ;
      endcase
    end
  end

  spu_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_busy_i (out_valid_o && out_stall_i),
    .idle_o     (idle),
    .ctrl_o     (ctrl)
  );

  spu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg_q),
    .sample_i    (samples),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .drive_o     (drive_o),
    .clipped_o   (clipped_o)
  );

endmodule
